/* rtl/core/lut_weight_dot_product_defines.svh */
// Assertion macros for the checker file of the LUT-weight dot-product block.
// Each macro expects clk and rst_n in scope.
`ifndef LUT_WEIGHT_DOT_PRODUCT_DEFINES_SVH
`define LUT_WEIGHT_DOT_PRODUCT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LWDP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lwdp: assertion failed");

// Next-cycle implication, checked outside reset.
`define LWDP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lwdp: assertion failed");

`endif

/* rtl/core/lwdp_pkg.sv */
// Package for the LUT-weight dot-product block: command codes, widths, queue entry type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lwdp_pkg;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_MAC   = 1'b1;

    localparam int IDX_W  = 16;
    localparam int VAL_W  = 16;
    localparam int PROD_W = 32;
    localparam int ACC_W  = 48;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef struct packed {
        logic signed [VAL_W-1:0] weight;
        logic signed [VAL_W-1:0] activation;
        logic                    last;
    } q_entry_t;

endpackage
`default_nettype wire

/* rtl/core/lwdp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module lwdp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

/* rtl/core/lwdp_front.sv */
// Front end: accepts transfers, writes the weight table, issues table lookups.
// Depends on lwdp_pkg and lwdp_ram.
`timescale 1ns / 1ps
`default_nettype none
module lwdp_front #(
    parameter int TABLE_DEPTH = 65536
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic                                cmd,
    input  wire logic        [lwdp_pkg::IDX_W-1:0]   table_index,
    input  wire logic signed [lwdp_pkg::VAL_W-1:0]   table_value,
    input  wire logic signed [lwdp_pkg::VAL_W-1:0]   activation,
    input  wire logic                                last,
    input  wire logic                                q_full,
    output logic                                     q_push,
    output lwdp_pkg::q_entry_t                       q_entry
);
    import lwdp_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    logic                    accept;
    logic                    in_range;
    logic                    wr_en;
    logic                    rd_en;
    logic [VAL_W-1:0]        rd_data;
    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    logic                    s1_hit_reg;
    logic signed [VAL_W-1:0] s1_act_reg;
    logic                    s1_last_reg;

    assign in_stall = s1_valid_reg & q_full;
    assign accept   = in_valid & ~in_stall;
    assign in_range = (32'(table_index) < TABLE_DEPTH);
    assign wr_en    = accept & (cmd == CMD_WRITE) & in_range;
    assign rd_en    = accept & (cmd == CMD_MAC);
    assign q_push   = s1_valid_reg & ~q_full;

    lwdp_ram #(
        .WIDTH (VAL_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (table_index[AW-1:0]),
        .wr_data (table_value),
        .rd_en   (rd_en),
        .rd_addr (table_index[AW-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (rd_en)
        begin
            s1_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            s1_hit_reg  <= in_range;
            s1_act_reg  <= activation;
            s1_last_reg <= last;
        end
    end

    // out-of-range lookups read as weight zero
    always_comb
    begin
        q_entry.weight     = s1_hit_reg ? signed'(rd_data) : '0;
        q_entry.activation = s1_act_reg;
        q_entry.last       = s1_last_reg;
    end

endmodule
`default_nettype wire

/* rtl/core/lwdp_queue.sv */
// Two-entry queue between front end and back end.
// Depends on lwdp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lwdp_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  lwdp_pkg::q_entry_t       push_entry,
    output logic                     full,
    input  wire logic                pop,
    output logic                     head_valid,
    output lwdp_pkg::q_entry_t       head_entry
);
    import lwdp_pkg::*;

    q_entry_t   slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_entry = slot_reg[rd_ptr_reg];
    assign do_push    = push & ~full;
    assign do_pop     = pop & head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/lwdp_back.sv */
// Back end: registered multiply, saturating 48-bit accumulate, result register.
// Depends on lwdp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lwdp_back (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               q_valid,
    input  lwdp_pkg::q_entry_t                      q_entry,
    output logic                                    q_pop,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic signed [lwdp_pkg::ACC_W-1:0]       dot_sum,
    output logic                                    overflowed
);
    import lwdp_pkg::*;

    logic                     pm_valid_reg;
    logic                     pm_valid_next;
    logic signed [PROD_W-1:0] pm_prod_reg;
    logic                     pm_last_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic                     sat_reg;
    logic                     sat_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [ACC_W-1:0]  dot_sum_reg;
    logic                     overflowed_reg;
    logic                     out_free;
    logic                     pm_adv;
    logic signed [ACC_W:0]    sum;
    logic                     sat_hi;
    logic                     sat_lo;
    logic signed [ACC_W-1:0]  clamped;

    assign out_free = ~out_valid_reg | ~out_stall;
    assign pm_adv   = pm_valid_reg & (~pm_last_reg | out_free);
    assign q_pop    = q_valid & (~pm_valid_reg | pm_adv);

    assign sum     = {acc_reg[ACC_W-1], acc_reg}
                   + {{(ACC_W+1-PROD_W){pm_prod_reg[PROD_W-1]}}, pm_prod_reg};
    assign sat_hi  = ~sum[ACC_W] & sum[ACC_W-1];
    assign sat_lo  = sum[ACC_W] & ~sum[ACC_W-1];
    assign clamped = sat_hi ? ACC_MAX : (sat_lo ? ACC_MIN : sum[ACC_W-1:0]);

    always_comb
    begin
        pm_valid_next = pm_valid_reg;
        if (q_pop)
        begin
            pm_valid_next = 1'b1;
        end
        else if (pm_adv)
        begin
            pm_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        acc_next       = acc_reg;
        sat_next       = sat_reg;
        out_valid_next = out_valid_reg & out_stall;
        if (pm_adv)
        begin
            if (pm_last_reg)
            begin
                acc_next       = '0;
                sat_next       = 1'b0;
                out_valid_next = 1'b1;
            end
            else
            begin
                acc_next = clamped;
                sat_next = sat_reg | sat_hi | sat_lo;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pm_valid_reg  <= 1'b0;
            acc_reg       <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pm_valid_reg  <= pm_valid_next;
            acc_reg       <= acc_next;
            sat_reg       <= sat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            pm_prod_reg <= q_entry.activation * q_entry.weight;
            pm_last_reg <= q_entry.last;
        end
        if (pm_adv && pm_last_reg)
        begin
            dot_sum_reg    <= clamped;
            overflowed_reg <= sat_reg | sat_hi | sat_lo;
        end
    end

    assign out_valid  = out_valid_reg;
    assign dot_sum    = dot_sum_reg;
    assign overflowed = overflowed_reg;

endmodule
`default_nettype wire

/* rtl/core/lut_weight_dot_product.sv */
// Top level of the LUT-weight dot-product block: front end, queue, back end.
// Depends on lwdp_pkg, lwdp_front, lwdp_queue, lwdp_back.
//
// Takes one transfer per clock while in_stall is low, table writes and
// multiply-accumulate pairs alike. A write lands in the weight table in the
// cycle it is accepted; a lookup reads the table's registered port, the product
// is registered, then added with 48-bit saturation. The result of a pair marked
// last passes the table read, queue, product and result registers in turn.
// A two-entry queue lets the input keep flowing while a result waits to be taken.
// The table has no reset; entries must be written before they are looked up.
`timescale 1ns / 1ps
`default_nettype none
module lut_weight_dot_product #(
    parameter int TABLE_DEPTH = 65536
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic                                cmd,
    input  wire logic        [lwdp_pkg::IDX_W-1:0]   table_index,
    input  wire logic signed [lwdp_pkg::VAL_W-1:0]   table_value,
    input  wire logic signed [lwdp_pkg::VAL_W-1:0]   activation,
    input  wire logic                                last,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic signed [lwdp_pkg::ACC_W-1:0]        dot_sum,
    output logic                                     overflowed
);
    import lwdp_pkg::*;

    logic     q_full;
    logic     q_push;
    logic     q_pop;
    logic     q_valid;
    q_entry_t push_entry;
    q_entry_t head_entry;

    lwdp_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .table_index (table_index),
        .table_value (table_value),
        .activation  (activation),
        .last        (last),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (push_entry)
    );

    lwdp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_entry (head_entry)
    );

    lwdp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_entry    (head_entry),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .dot_sum    (dot_sum),
        .overflowed (overflowed)
    );

endmodule
`default_nettype wire

/* rtl/core/lwdp_checker.sv */
// Port-level assertions for lut_weight_dot_product, bound to the top level.
// Depends on lut_weight_dot_product_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "lut_weight_dot_product_defines.svh"
module lwdp_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire logic signed [47:0] dot_sum,
    input wire logic               overflowed
);

    // a stalled result holds
    `LWDP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(dot_sum) && $stable(overflowed))

    // a cycle with the output free drains the queue enough to take input
    `LWDP_ASSERT_NEXT(a_no_stall_when_drained, !out_stall, !in_stall)

    // reset leaves no result pending and input open
    `LWDP_ASSERT_NOW(a_reset_clean, $rose(rst_n), !out_valid && !in_stall)

endmodule

bind lut_weight_dot_product lwdp_checker u_lwdp_checker (.*);
`default_nettype wire
